// ===== rtl/scpa_pkg.sv =====
// scpa_pkg: shared constants and types of the size-class pool allocator
// no dependencies
`default_nettype none
package scpa_pkg;
	localparam int unsigned BlockBytes    = 8;
	localparam int unsigned SizeClasses   = 16;
	localparam int unsigned MaxSmallBytes = 128;
	localparam int unsigned RefillChunks  = 20;
	localparam int unsigned ArenaBytes    = 4096;

	localparam int unsigned CapW   = 13;
	localparam int unsigned ReqW   = 16;
	localparam int unsigned AddrW  = 12;
	localparam int unsigned StatW  = 2;
	localparam logic [CapW-1:0] CapReset = CapW'(1000);

	typedef enum logic [StatW-1:0] {
		ST_ALLOC = 2'd0,
		ST_FREED = 2'd1,
		ST_LARGE = 2'd2,
		ST_OOM   = 2'd3
	} status_t;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/scpa_link_ram.sv =====
// scpa_link_ram: link store, one synchronous write and one registered read port
// depends on nothing but its parameters
`default_nettype none
module scpa_link_ram #(
	parameter int unsigned DEPTH = 512,
	parameter int unsigned WIDTH = 10
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/size_class_pool_allocator.sv =====
// size_class_pool_allocator: top level, sequencer, list heads, pool registers
// depends on scpa_pkg and scpa_link_ram
//
//  channel | direction | signals
//  in      | to block  | in_valid, in_ready, command, request_bytes, block_address
//  out     | from      | out_valid, out_ready, granted_address, status
//  cfg     | to block  | cfg_we, cfg_wdata (growth_cap)
//
// a free passes S_DEC and S_RESP; a hit on a list head also waits in S_HIT for the link store read
// a refill may divide left by size in S_DIV, grow the pool in S_GROW or borrow
// a larger free block in S_BSCAN and S_BLINK, then links its chunks in S_LINK
// one item is worked at a time; in_ready is low until the result is taken
// the output register holds the result under back pressure
// reset empties the list heads and the pool; the link store needs no clearing
`default_nettype none
module size_class_pool_allocator
	import scpa_pkg::*;
#(
	parameter int unsigned BLOCK_BYTES     = scpa_pkg::BlockBytes,
	parameter int unsigned SIZE_CLASSES    = scpa_pkg::SizeClasses,
	parameter int unsigned MAX_SMALL_BYTES = scpa_pkg::MaxSmallBytes,
	parameter int unsigned REFILL_CHUNKS   = scpa_pkg::RefillChunks,
	parameter int unsigned ARENA_BYTES     = scpa_pkg::ArenaBytes
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          command,
	input  wire logic [scpa_pkg::ReqW-1:0]     request_bytes,
	input  wire logic [scpa_pkg::AddrW-1:0]    block_address,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [scpa_pkg::AddrW-1:0]    granted_address,
	output logic      [scpa_pkg::StatW-1:0]    status,
	input  wire logic                          cfg_we,
	input  wire logic [scpa_pkg::CapW-1:0]     cfg_wdata
);
	localparam int unsigned NB    = ARENA_BYTES / BLOCK_BYTES;
	localparam int unsigned BW    = $clog2(NB);
	localparam int unsigned LW    = BW + 1;            // link: block + 1, 0 is end
	localparam int unsigned CW    = $clog2(SIZE_CLASSES);
	localparam int unsigned SH    = $clog2(BLOCK_BYTES);
	localparam int unsigned PW    = $clog2(ARENA_BYTES) + 1; // pool byte values
	localparam int unsigned SW    = $clog2(SIZE_CLASSES * BLOCK_BYTES) + 1;
	localparam int unsigned NW    = $clog2(REFILL_CHUNKS) + 1;
	localparam int unsigned TW    = PW + SW + NW;    // wide enough for size*count*2
	localparam int unsigned QW    = PW;              // quotient width

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_DEC    = 11'b00000000010,
		S_HIT    = 11'b00000000100,
		S_CARVE  = 11'b00000001000,
		S_DIV    = 11'b00000010000,
		S_GROW   = 11'b00000100000,
		S_BSCAN  = 11'b00001000000,
		S_BLINK  = 11'b00010000000,
		S_LINK   = 11'b00100000000,
		S_DONE   = 11'b01000000000,
		S_RESP   = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [CapW-1:0]  growth_cap_q;
	logic [LW-1:0]    heads_q [SIZE_CLASSES];
	logic [PW-1:0]    pool_start_q, pool_end_q;
	logic [PW-1:0]    heap_taken_q;

	// item registers
	logic             cmd_q;
	logic [ReqW-1:0]  n_q;
	logic [AddrW-1:0] addr_q;
	logic [CW-1:0]    cls_q;
	logic [SW-1:0]    size_q;
	logic [NW-1:0]    count_q;
	logic [NW-1:0]    idx_q;
	logic [PW-1:0]    base_q;
	logic [PW-1:0]    cur_q;
	logic [CW:0]      scan_q;
	logic [LW-1:0]    bblk_q;
	logic [PW-1:0]    rem_q;
	logic [QW-1:0]    quo_q;
	logic [$clog2(QW+1)-1:0] dcnt_q;

	// output register
	logic             ovalid_q;
	logic [AddrW-1:0] oaddr_q;
	status_t          ostat_q;

	// link store port
	logic          l_we;
	logic [BW-1:0] l_waddr, l_raddr;
	logic [LW-1:0] l_wdata, l_rdata;

	scpa_link_ram #(.DEPTH(NB), .WIDTH(LW)) u_links (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata)
	);

	assign in_ready        = (state_q == S_IDLE) && !ovalid_q;
	assign out_valid       = ovalid_q;
	assign granted_address = oaddr_q;
	assign status          = ostat_q;

	// decode of the request size
	logic [ReqW-1:0] n_eff;
	logic [ReqW-1:0] blocks;
	logic            too_large;
	always_comb begin
		n_eff     = (n_q == '0) ? ReqW'(1) : n_q;
		blocks    = ReqW'((32'(n_eff) + BLOCK_BYTES - 1) >> SH);
		too_large = (32'(n_eff) > MAX_SMALL_BYTES) || (32'(blocks) > SIZE_CLASSES);
	end

	// pool arithmetic
	logic [PW-1:0] left;
	logic [TW-1:0] total;
	logic [TW-1:0] grow;
	logic [PW-1:0] heap_round;
	logic [TW-1:0] heap_sum;
	logic          grow_ok;
	always_comb begin
		left       = (pool_end_q > pool_start_q) ? pool_end_q - pool_start_q : '0;
		total      = TW'(size_q) * TW'(count_q);
		heap_round = PW'((((heap_taken_q >> 4) + PW'(BLOCK_BYTES - 1)) >> SH) << SH);
		grow       = (total << 1) + TW'(heap_round);
		heap_sum   = TW'(heap_taken_q) + grow;
		grow_ok    = (TW'(heap_taken_q) <= TW'(growth_cap_q))
			&& (heap_sum <= TW'(ARENA_BYTES));
	end

	// restoring division step, left / size, one quotient bit a cycle
	logic [PW:0]   trial;
	logic [PW-1:0] next_rem;
	always_comb begin
		next_rem = {rem_q[PW-2:0], quo_q[QW-1]};
		trial    = {1'b0, next_rem} - (PW+1)'(size_q);
	end

	// link write during refill: chunk idx at cur_q, next chunk or end
	logic [PW-1:0] nxt_byte;
	logic [LW-1:0] nxt_link;
	always_comb begin
		nxt_byte = cur_q + PW'(size_q);
		nxt_link = ((idx_q + 1'b1) < count_q) ? LW'((nxt_byte >> SH) + 1) : '0;
	end

	logic [PW-1:0] left_blocks;
	assign left_blocks = left >> SH;

	always_comb begin
		l_we    = 1'b0;
		l_waddr = '0;
		l_wdata = '0;
		l_raddr = '0;
		unique case (state_q)
			S_DEC: begin
				if (cmd_q == CMD_FREE) begin
					l_we    = !too_large && (32'(addr_q >> SH) < NB);
					l_waddr = BW'(addr_q >> SH);
					l_wdata = heads_q[CW'(blocks - 1'b1)];
				end else begin
					l_raddr = BW'(heads_q[CW'(blocks - 1'b1)] - 1'b1);
				end
			end
			S_CARVE: begin
				// leftover push when not even one chunk fits
				l_we    = (left < PW'(size_q)) && (left < PW'(total)) && (left_blocks != 0)
					&& (32'(left_blocks) <= SIZE_CLASSES) && (32'(pool_start_q >> SH) < NB);
				l_waddr = BW'(pool_start_q >> SH);
				l_wdata = heads_q[CW'(left_blocks - 1'b1)];
			end
			S_BSCAN: l_raddr = BW'(heads_q[CW'(scan_q)] - 1'b1);
			S_LINK: begin
				l_we    = (32'(cur_q >> SH) < NB);
				l_waddr = BW'(cur_q >> SH);
				l_wdata = nxt_link;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			growth_cap_q <= CapReset;
			for (int i = 0; i < SIZE_CLASSES; i++) heads_q[i] <= '0;
			pool_start_q <= '0;
			pool_end_q   <= '0;
			heap_taken_q <= '0;
			ovalid_q     <= 1'b0;
		end else begin
			if (cfg_we) growth_cap_q <= cfg_wdata;
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q   <= command;
						n_q     <= request_bytes;
						addr_q  <= block_address;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					cls_q   <= CW'(blocks - 1'b1);
					size_q  <= SW'(blocks << SH);
					count_q <= NW'(REFILL_CHUNKS);
					if (too_large) begin
						oaddr_q <= '0;
						ostat_q <= ST_LARGE;
						state_q <= S_RESP;
					end else if (cmd_q == CMD_FREE) begin
						if (32'(addr_q >> SH) < NB)
							heads_q[CW'(blocks - 1'b1)] <= LW'((addr_q >> SH) + 1);
						oaddr_q <= '0;
						ostat_q <= ST_FREED;
						state_q <= S_RESP;
					end else if (heads_q[CW'(blocks - 1'b1)] != '0) begin
						oaddr_q <= AddrW'(32'(heads_q[CW'(blocks - 1'b1)] - 1'b1) << SH);
						ostat_q <= ST_ALLOC;
						state_q <= S_HIT;
					end else begin
						state_q <= S_CARVE;
					end
				end
				S_HIT: begin
					heads_q[cls_q] <= l_rdata;
					state_q        <= S_RESP;
				end
				S_CARVE: begin
					if (TW'(left) >= total) begin
						base_q       <= pool_start_q;
						pool_start_q <= pool_start_q + PW'(total);
						state_q      <= S_DONE;
					end else if (left >= PW'(size_q)) begin
						rem_q   <= '0;
						quo_q   <= left;
						dcnt_q  <= '0;
						state_q <= S_DIV;
					end else begin
						if (l_we) heads_q[CW'(left_blocks - 1'b1)] <= LW'((pool_start_q >> SH) + 1);
						pool_start_q <= pool_end_q;
						state_q      <= S_GROW;
					end
				end
				S_DIV: begin
					if (32'(dcnt_q) < QW) begin
						if (!trial[PW]) begin
							rem_q <= trial[PW-1:0];
							quo_q <= {quo_q[QW-2:0], 1'b1};
						end else begin
							rem_q <= next_rem;
							quo_q <= {quo_q[QW-2:0], 1'b0};
						end
						dcnt_q <= dcnt_q + 1'b1;
					end else begin
						// quotient is below REFILL_CHUNKS here
						count_q <= NW'(quo_q);
						base_q  <= pool_start_q;
						pool_start_q <= pool_start_q + PW'(TW'(size_q) * TW'(quo_q));
						state_q <= S_DONE;
					end
				end
				S_GROW: begin
					if (grow_ok) begin
						pool_start_q <= heap_taken_q;
						pool_end_q   <= PW'(heap_sum);
						heap_taken_q <= PW'(heap_sum);
						state_q      <= S_CARVE;
					end else begin
						scan_q  <= (CW+1)'(cls_q) + 1'b1;
						state_q <= S_BSCAN;
					end
				end
				S_BSCAN: begin
					if (32'(scan_q) >= SIZE_CLASSES) begin
						pool_start_q <= pool_end_q;
						oaddr_q      <= '0;
						ostat_q      <= ST_OOM;
						state_q      <= S_RESP;
					end else if (heads_q[CW'(scan_q)] != '0) begin
						bblk_q  <= heads_q[CW'(scan_q)] - 1'b1;
						state_q <= S_BLINK;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_BLINK: begin
					heads_q[CW'(scan_q)] <= l_rdata;
					pool_start_q <= PW'(bblk_q) << SH;
					if (((32'(bblk_q) << SH) + ((32'(scan_q) + 1) << SH)) > ARENA_BYTES)
						pool_end_q <= PW'(ARENA_BYTES);
					else
						pool_end_q <= PW'((32'(bblk_q) << SH) + ((32'(scan_q) + 1) << SH));
					state_q <= S_CARVE;
				end
				S_DONE: begin
					oaddr_q <= AddrW'(base_q);
					ostat_q <= ST_ALLOC;
					if (count_q > NW'(1)) begin
						heads_q[cls_q] <= LW'(((base_q + PW'(size_q)) >> SH) + 1);
						cur_q   <= base_q + PW'(size_q);
						idx_q   <= NW'(1);
						state_q <= S_LINK;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_LINK: begin
					cur_q <= nxt_byte;
					idx_q <= idx_q + 1'b1;
					if ((idx_q + 1'b1) >= count_q) state_q <= S_RESP;
				end
				S_RESP: begin
					ovalid_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_resp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(state_q) == S_RESP)
		else $error("result raised outside response state");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("input ready while busy");
	a_pool_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (pool_start_q <= PW'(ARENA_BYTES)))
		else $error("pool start beyond arena");
endmodule
`default_nettype wire
